@@ design/wavetable_additive_band_mixer_top_macros.svh @@
// assertion macros for the band mixer
`ifndef WAVETABLE_ADDITIVE_BAND_MIXER_TOP_MACROS_SVH
`define WAVETABLE_ADDITIVE_BAND_MIXER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ design/wabm_pkg.sv @@
// shared types and constants of the band mixer
`timescale 1ns / 1ps
package wabm_pkg;
  localparam int BANDS_DEF          = 64;
  localparam int MAX_WAVELENGTH_DEF = 2048;
  localparam int RAMP_SAMPLES_DEF   = 220;
  localparam int COLORS             = 3;
  localparam int ENERGY_FLOOR       = 3;
  localparam int QUEUE_DEPTH        = 2;
  localparam logic [6:0]  ACTIVE_BANDS_RST   = 7'd64;
  localparam logic [15:0] SEGMENT_LENGTH_RST = 16'd2646;

  typedef enum logic [1:0] {
    CMD_SETUP    = 2'd0,
    CMD_WORD     = 2'd1,
    CMD_ENERGY   = 2'd2,
    CMD_GENERATE = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_ACTIVE_BANDS   = 1'b0,
    REG_SEGMENT_LENGTH = 1'b1
  } reg_index_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [5:0]         band;
    logic [1:0]         color;
    logic [10:0]        table_index;
    logic signed [15:0] table_value;
    logic [11:0]        wavelength;
    logic [15:0]        pan_value;
    logic [15:0]        offset_value;
    logic [15:0]        energy_value;
    logic [15:0]        position;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EN_READ,
    ST_EN_WRITE,
    ST_BAND,
    ST_SETUP,
    ST_VOICE,
    ST_ENERGY,
    ST_MUL_K,
    ST_MUL_RECIP,
    ST_MUL_BACK,
    ST_CORRECT,
    ST_AMP,
    ST_PAN,
    ST_ACC,
    ST_NEXT,
    ST_OUT
  } state_t;
endpackage

@@ design/wavetable_additive_band_mixer_top.sv @@
// top level of the wavetable band mixer
//
//   port group   | dir | handshake            | carries
//   -------------+-----+----------------------+-------------------------------
//   input beat   | in  | in_valid / in_ready  | cmd, band, color, table and load fields
//   result beat  | out | out_valid / out_ready| left_sample, right_sample, clipped
//   register     | in  | cfg_we               | cfg_index, cfg_data
//
// setup and wavetable loads are done as the back end pops them; energy loads
// read the current energy, then shift it into the previous slot.
// a generate walks every band in turn; each live voice goes through the
// single shared multiply chain of the voice sequencer, and each store has
// one read port.
// reset clears the energy and phase valid bits at once, no sweep.
// the two-entry queue keeps taking beats while the back end works or a
// result waits for out_ready.
`timescale 1ns / 1ps
`include "wavetable_additive_band_mixer_top_macros.svh"
module wavetable_additive_band_mixer_top #(
  parameter int BANDS          = wabm_pkg::BANDS_DEF,
  parameter int MAX_WAVELENGTH = wabm_pkg::MAX_WAVELENGTH_DEF,
  parameter int RAMP_SAMPLES   = wabm_pkg::RAMP_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [5:0]         band,
  input  logic [1:0]         color,
  input  logic [10:0]        table_index,
  input  logic signed [15:0] table_value,
  input  logic [11:0]        wavelength,
  input  logic [15:0]        pan_value,
  input  logic [15:0]        offset_value,
  input  logic [15:0]        energy_value,
  input  logic [15:0]        position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic               clipped,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import wabm_pkg::*;

  item_t         q_in, q_head;
  queue_status_t q_status;
  logic          q_push, q_pop;
  logic [6:0]    active_bands;
  logic [15:0]   segment_length;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_bands   <= ACTIVE_BANDS_RST;
      segment_length <= SEGMENT_LENGTH_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ACTIVE_BANDS:   active_bands   <= cfg_data[6:0];
        REG_SEGMENT_LENGTH: segment_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front end
  wabm_front #(
    .BANDS          (BANDS),
    .MAX_WAVELENGTH (MAX_WAVELENGTH)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .band         (band),
    .color        (color),
    .table_index  (table_index),
    .table_value  (table_value),
    .wavelength   (wavelength),
    .pan_value    (pan_value),
    .offset_value (offset_value),
    .energy_value (energy_value),
    .position     (position),
    .q_status     (q_status),
    .push         (q_push),
    .item         (q_in)
  );

  // command queue
  wabm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  // back end
  wabm_back #(
    .BANDS          (BANDS),
    .MAX_WAVELENGTH (MAX_WAVELENGTH),
    .RAMP_SAMPLES   (RAMP_SAMPLES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_head),
    .q_status       (q_status),
    .pop            (q_pop),
    .active_bands   (active_bands),
    .segment_length (segment_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .clipped        (clipped)
  );

  // checks
  `ASSERT_IMPLY(a_push_has_room, clk, rst, q_push, !q_status.full)
  `ASSERT_IMPLY(a_pop_has_beat, clk, rst, q_pop, !q_status.empty)
  `ASSERT_NEXT(a_reset_clean, clk, 1'b0, rst, !out_valid && q_status.empty)
endmodule

@@ design/wabm_front.sv @@
// front end: accepts input beats, drops ignored loads, feeds the queue
`timescale 1ns / 1ps
module wabm_front #(
  parameter int BANDS          = wabm_pkg::BANDS_DEF,
  parameter int MAX_WAVELENGTH = wabm_pkg::MAX_WAVELENGTH_DEF
) (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             cmd,
  input  logic [5:0]             band,
  input  logic [1:0]             color,
  input  logic [10:0]            table_index,
  input  logic signed [15:0]     table_value,
  input  logic [11:0]            wavelength,
  input  logic [15:0]            pan_value,
  input  logic [15:0]            offset_value,
  input  logic [15:0]            energy_value,
  input  logic [15:0]            position,
  input  wabm_pkg::queue_status_t q_status,
  output logic                   push,
  output wabm_pkg::item_t        item
);
  import wabm_pkg::*;

  logic band_ok, color_ok, index_ok, keep;

  // range checks on the addressed entry
  always_comb begin
    band_ok  = int'(band) < BANDS;
    color_ok = int'(color) < COLORS;
    index_ok = int'(table_index) < MAX_WAVELENGTH;
  end

  // loads that address nothing are taken and dropped
  always_comb begin
    case (cmd_t'(cmd))
      CMD_SETUP:    keep = band_ok;
      CMD_WORD:     keep = band_ok && color_ok && index_ok;
      CMD_ENERGY:   keep = band_ok && color_ok;
      CMD_GENERATE: keep = 1'b1;
      default:      keep = 1'b0;
    endcase
  end

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready && keep;

  // pack the beat
  always_comb begin
    item.cmd          = cmd_t'(cmd);
    item.band         = band;
    item.color        = color;
    item.table_index  = table_index;
    item.table_value  = table_value;
    item.wavelength   = wavelength;
    item.pan_value    = pan_value;
    item.offset_value = offset_value;
    item.energy_value = energy_value;
    item.position     = position;
  end
endmodule

@@ design/wabm_queue.sv @@
// short command queue between front and back
`timescale 1ns / 1ps
module wabm_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  wabm_pkg::item_t         push_item,
  input  logic                    pop,
  output wabm_pkg::item_t         head,
  output wabm_pkg::queue_status_t status
);
  import wabm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
endmodule

@@ design/wabm_back.sv @@
// back end: executes loads and walks the bank for each generate
`timescale 1ns / 1ps
module wabm_back #(
  parameter int BANDS          = wabm_pkg::BANDS_DEF,
  parameter int MAX_WAVELENGTH = wabm_pkg::MAX_WAVELENGTH_DEF,
  parameter int RAMP_SAMPLES   = wabm_pkg::RAMP_SAMPLES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  wabm_pkg::item_t         head,
  input  wabm_pkg::queue_status_t q_status,
  output logic                    pop,
  input  logic [6:0]              active_bands,
  input  logic [15:0]             segment_length,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [15:0]      left_sample,
  output logic signed [15:0]      right_sample,
  output logic                    clipped
);
  import wabm_pkg::*;

  localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int WL_W    = $clog2(MAX_WAVELENGTH + 1);
  localparam int PH_W    = $clog2(MAX_WAVELENGTH);
  localparam int EV_N    = COLORS * BANDS;
  localparam int EV_W    = $clog2(EV_N);
  localparam int WA_N    = COLORS * BANDS * MAX_WAVELENGTH;
  localparam int WA_W    = $clog2(WA_N);
  localparam int K_W     = $clog2(RAMP_SAMPLES + 1);
  localparam int SHIFT   = $clog2(RAMP_SAMPLES) + 16;
  localparam int X_W     = SHIFT;
  localparam int RECIP   = (2 ** SHIFT) / RAMP_SAMPLES;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PR_W    = X_W + RECIP_W;
  localparam int ST_W    = 17;
  localparam int AMP_W   = 33;
  localparam int TERM_W  = AMP_W + 18;
  localparam int ACC_W   = 49 + $clog2(EV_N);

  localparam logic [K_W-1:0]       RAMP_K   = K_W'(RAMP_SAMPLES);
  localparam logic [RECIP_W-1:0]   RECIP_C  = RECIP_W'(RECIP);
  localparam logic [ST_W-1:0]      RAMP_ST  = ST_W'(RAMP_SAMPLES);
  localparam logic signed [ACC_W-1:0] UNITY = {{(ACC_W - 48){1'b0}}, 1'b1, 47'd0};
  localparam logic signed [ACC_W-1:0] NEG_UNITY = -UNITY;

  // truncate toward zero to Q1.15, then saturate
  function automatic logic [15:0] to_q15(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0]  adj;
    logic signed [ACC_W-33:0] q;
    adj = a[ACC_W-1] ? (a + ACC_W'(33'h0_FFFF_FFFF)) : a;
    q   = adj[ACC_W-1:32];
    if (q > 32767) begin
      to_q15 = 16'h7FFF;
    end else if (q < -32768) begin
      to_q15 = 16'h8000;
    end else begin
      to_q15 = q[15:0];
    end
  endfunction

  // memories
  logic signed [15:0] wave_mem [WA_N];
  logic [11:0]        wl_mem   [BANDS];
  logic [15:0]        pan_mem  [BANDS];
  logic [15:0]        off_mem  [BANDS];
  logic [PH_W-1:0]    ph_mem   [BANDS];
  logic [15:0]        now_mem  [EV_N];
  logic [15:0]        bef_mem  [EV_N];
  logic [BANDS-1:0]   ph_vld;
  logic [EV_N-1:0]    ev_vld;

  state_t state, state_next;

  // control outputs of the sequencer
  logic             wave_we, setup_we, ph_we, band_rd, voice_rd, ev_rd, ev_we;
  logic [WA_W-1:0]  wave_wr_addr, wave_rd_addr;
  logic [BAND_W-1:0] head_band, ph_wr_addr;
  logic [PH_W-1:0]  ph_wr_data;
  logic [EV_W-1:0]  ev_rd_addr, ev_cur, ev_voice;
  logic             out_load;

  // registered read data
  logic signed [15:0] wave_rd;
  logic [11:0]        wl_rd;
  logic [15:0]        pan_rd, off_rd, now_rd, bef_rd;
  logic [PH_W-1:0]    ph_rd;
  logic               ph_vld_rd, ev_vld_rd;

  // working registers
  item_t              cur;
  logic [BAND_W-1:0]  b;
  logic [1:0]         c;
  logic [PH_W-1:0]    ph_cur;
  logic [ST_W-1:0]    win_start, win_end;
  logic [15:0]        pl;
  logic [15:0]        e_now, e_bef, e_val, q0;
  logic signed [15:0] wave_q;
  logic               in_ramp, past_end, d_neg;
  logic [K_W-1:0]     k;
  logic [15:0]        d_mag;
  logic [X_W-1:0]     x, qr;
  logic signed [AMP_W-1:0]  amp;
  logic signed [TERM_W-1:0] tl, tr;
  logic signed [ACC_W-1:0]  acc_l, acc_r, acc_l_next, acc_r_next;
  logic               clip;

  // band setup decode of the read word
  logic [12:0]        wl_wide;
  logic [WL_W-1:0]    wl_eff, np;
  logic [PH_W-1:0]    ph_raw, ph_use, ph_next;
  logic [ST_W-1:0]    st_calc, end_calc;

  // energy decode of the read word
  logic [15:0]        now_eff, bef_eff;
  logic [ST_W-1:0]    pos_w;
  logic               voice_live;
  logic [X_W-1:0]     rem;
  logic [15:0]        q_fix;
  logic [16:0]        pr;

  assign head_band = BAND_W'(head.band);
  assign ev_cur    = EV_W'(EV_W'(cur.color) * EV_W'(BANDS) + EV_W'(cur.band));
  assign ev_voice  = EV_W'(EV_W'(c) * EV_W'(BANDS) + EV_W'(b));
  assign out_load  = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_status.empty) begin
          case (head.cmd)
            CMD_ENERGY:   state_next = ST_EN_READ;
            CMD_GENERATE: state_next = ST_BAND;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_EN_READ:   state_next = ST_EN_WRITE;
      ST_EN_WRITE:  state_next = ST_IDLE;
      ST_BAND:      state_next = ST_SETUP;
      ST_SETUP:     state_next = (int'(b) < int'(active_bands)) ? ST_VOICE : ST_NEXT;
      ST_VOICE:     state_next = ST_ENERGY;
      ST_ENERGY: begin
        if (voice_live) begin
          state_next = ST_MUL_K;
        end else begin
          state_next = (c == 2'(COLORS - 1)) ? ST_NEXT : ST_VOICE;
        end
      end
      ST_MUL_K:     state_next = ST_MUL_RECIP;
      ST_MUL_RECIP: state_next = ST_MUL_BACK;
      ST_MUL_BACK:  state_next = ST_CORRECT;
      ST_CORRECT:   state_next = ST_AMP;
      ST_AMP:       state_next = ST_PAN;
      ST_PAN:       state_next = ST_ACC;
      ST_ACC:       state_next = (c == 2'(COLORS - 1)) ? ST_NEXT : ST_VOICE;
      ST_NEXT:      state_next = (b == BAND_W'(BANDS - 1)) ? ST_OUT : ST_BAND;
      ST_OUT:       state_next = out_load ? ST_IDLE : ST_OUT;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop          = 1'b0;
    wave_we      = 1'b0;
    setup_we     = 1'b0;
    ph_we        = 1'b0;
    band_rd      = 1'b0;
    voice_rd     = 1'b0;
    ev_rd        = 1'b0;
    ev_we        = 1'b0;
    ph_wr_addr   = b;
    ph_wr_data   = ph_next;
    ev_rd_addr   = ev_voice;
    wave_wr_addr = WA_W'(WA_W'(EV_W'(EV_W'(head.color) * EV_W'(BANDS) + EV_W'(head_band)))
                   * WA_W'(MAX_WAVELENGTH) + WA_W'(head.table_index));
    wave_rd_addr = WA_W'(WA_W'(ev_voice) * WA_W'(MAX_WAVELENGTH) + WA_W'(ph_cur));
    case (state)
      ST_IDLE: begin
        pop = !q_status.empty;
        if (!q_status.empty) begin
          wave_we    = (head.cmd == CMD_WORD);
          setup_we   = (head.cmd == CMD_SETUP);
          ph_we      = (head.cmd == CMD_SETUP);
          ph_wr_addr = head_band;
          ph_wr_data = '0;
        end
      end
      ST_EN_READ: begin
        ev_rd      = 1'b1;
        ev_rd_addr = ev_cur;
      end
      ST_EN_WRITE: ev_we = 1'b1;
      ST_BAND:     band_rd = 1'b1;
      ST_SETUP:    ph_we = 1'b1;
      ST_VOICE: begin
        ev_rd    = 1'b1;
        voice_rd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // wavetable store
  always_ff @(posedge clk) begin
    if (wave_we) begin
      wave_mem[wave_wr_addr] <= head.table_value;
    end
    if (voice_rd) begin
      wave_rd <= wave_mem[wave_rd_addr];
    end
  end

  // band setup store
  always_ff @(posedge clk) begin
    if (setup_we) begin
      wl_mem[head_band]  <= head.wavelength;
      pan_mem[head_band] <= head.pan_value;
      off_mem[head_band] <= head.offset_value;
    end
    if (band_rd) begin
      wl_rd  <= wl_mem[b];
      pan_rd <= pan_mem[b];
      off_rd <= off_mem[b];
    end
  end

  // phase store with reset-cleared valid bits
  always_ff @(posedge clk) begin
    if (ph_we) begin
      ph_mem[ph_wr_addr] <= ph_wr_data;
    end
    if (band_rd) begin
      ph_rd <= ph_mem[b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_vld    <= '0;
      ph_vld_rd <= 1'b0;
    end else begin
      if (ph_we) begin
        ph_vld[ph_wr_addr] <= 1'b1;
      end
      if (band_rd) begin
        ph_vld_rd <= ph_vld[b];
      end
    end
  end

  // energy stores with reset-cleared valid bits, one bit covers both slots
  always_ff @(posedge clk) begin
    if (ev_we) begin
      bef_mem[ev_cur] <= now_eff;
      now_mem[ev_cur] <= cur.energy_value;
    end
    if (ev_rd) begin
      now_rd <= now_mem[ev_rd_addr];
      bef_rd <= bef_mem[ev_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_vld    <= '0;
      ev_vld_rd <= 1'b0;
    end else begin
      if (ev_we) begin
        ev_vld[ev_cur] <= 1'b1;
      end
      if (ev_rd) begin
        ev_vld_rd <= ev_vld[ev_rd_addr];
      end
    end
  end

  // band word decode: wavelength clamp, phase, ramp window
  always_comb begin
    wl_wide = {1'b0, wl_rd};
    if (wl_wide == 13'd0) begin
      wl_eff = WL_W'(1);
    end else if (int'(wl_wide) > MAX_WAVELENGTH) begin
      wl_eff = WL_W'(MAX_WAVELENGTH);
    end else begin
      wl_eff = WL_W'(wl_wide);
    end
    ph_raw  = ph_vld_rd ? ph_rd : '0;
    ph_use  = (WL_W'(ph_raw) >= wl_eff) ? '0 : ph_raw;
    np      = WL_W'(ph_raw) + 1'b1;
    ph_next = (np >= wl_eff) ? '0 : PH_W'(np);
    st_calc = ({1'b0, off_rd} >= RAMP_ST) ? ({1'b0, off_rd} - RAMP_ST) : '0;
    end_calc = st_calc + RAMP_ST;
    if (end_calc >= {1'b0, segment_length}) begin
      end_calc = {1'b0, segment_length};
    end
  end

  // voice word decode and ramp quotient fix-up
  always_comb begin
    now_eff    = ev_vld_rd ? now_rd : '0;
    bef_eff    = ev_vld_rd ? bef_rd : '0;
    pos_w      = {1'b0, cur.position};
    voice_live = (int'(now_eff) > ENERGY_FLOOR) || (int'(bef_eff) > ENERGY_FLOOR);
    rem        = x - qr;
    q_fix      = (rem >= X_W'(RAMP_K)) ? (q0 + 1'b1) : q0;
    pr         = 17'h1_0000 - {1'b0, pl};
    acc_l_next = acc_l + ACC_W'(tl);
    acc_r_next = acc_r + ACC_W'(tr);
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur   <= head;
        b     <= '0;
        acc_l <= '0;
        acc_r <= '0;
        clip  <= 1'b0;
      end
      ST_SETUP: begin
        ph_cur    <= ph_use;
        win_start <= st_calc;
        win_end   <= end_calc;
        pl        <= pan_rd;
        c         <= '0;
      end
      ST_ENERGY: begin
        e_now    <= now_eff;
        e_bef    <= bef_eff;
        wave_q   <= wave_rd;
        in_ramp  <= (pos_w > win_start) && (pos_w < win_end);
        past_end <= (pos_w >= win_end);
        k        <= K_W'(pos_w - win_start);
        d_neg    <= (now_eff < bef_eff);
        d_mag    <= (now_eff < bef_eff) ? (bef_eff - now_eff) : (now_eff - bef_eff);
        if (!voice_live) begin
          c <= c + 1'b1;
        end
      end
      ST_MUL_K:     x  <= X_W'(X_W'(k) * X_W'(d_mag));
      ST_MUL_RECIP: q0 <= 16'((PR_W'(x) * PR_W'(RECIP_C)) >> SHIFT);
      ST_MUL_BACK:  qr <= X_W'(q0) * X_W'(RAMP_K);
      ST_CORRECT: begin
        if (in_ramp) begin
          e_val <= d_neg ? (e_bef - q_fix) : (e_bef + q_fix);
        end else begin
          e_val <= past_end ? e_now : e_bef;
        end
      end
      ST_AMP: amp <= wave_q * $signed({1'b0, e_val});
      ST_PAN: begin
        tl <= amp * $signed({2'b00, pl});
        tr <= amp * $signed({1'b0, pr});
      end
      ST_ACC: begin
        acc_l <= acc_l_next;
        acc_r <= acc_r_next;
        if (acc_l_next > UNITY || acc_l_next < NEG_UNITY ||
            acc_r_next > UNITY || acc_r_next < NEG_UNITY) begin
          clip <= 1'b1;
        end
        c <= c + 1'b1;
      end
      ST_NEXT: b <= b + 1'b1;
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_load) begin
      left_sample  <= to_q15(acc_l);
      right_sample <= to_q15(acc_r);
      clipped      <= clip;
    end
  end
endmodule

@@ dv/tb_wavetable_additive_band_mixer_top.sv @@
// self-checking testbench for the wavetable band mixer top level
`timescale 1ns / 1ps
module tb_wavetable_additive_band_mixer_top;
  import wabm_pkg::*;

  localparam int NB = BANDS_DEF;
  localparam int MAXWL = MAX_WAVELENGTH_DEF;
  localparam int RAMP = RAMP_SAMPLES_DEF;
  localparam longint UNITY = longint'(1) << 47;
  localparam longint SCALE = longint'(1) << 32;
  localparam int SETTLE = 60;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct {
    logic signed [15:0] l;
    logic signed [15:0] r;
    logic c;
  } mix_t;

  typedef struct {
    item_t it;
    bit typed;
    mix_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = '0;
  logic [5:0] band = '0;
  logic [1:0] color = '0;
  logic [10:0] table_index = '0;
  logic signed [15:0] table_value = '0;
  logic [11:0] wavelength = '0;
  logic [15:0] pan_value = '0;
  logic [15:0] offset_value = '0;
  logic [15:0] energy_value = '0;
  logic [15:0] position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic clipped;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  wavetable_additive_band_mixer_top dut (.*);

  always #5 clk = ~clk;

  // mixer state as the bank should hold it
  int unsigned wave_words [int unsigned];
  int unsigned band_wl [NB];
  int unsigned band_pan_q [NB];
  int unsigned band_off [NB];
  int unsigned energy_cur [COLORS*NB];
  int unsigned energy_old [COLORS*NB];
  int unsigned phase_ctr [NB];
  int unsigned nbands_cfg = 64;
  int unsigned seglen_cfg = 2646;

  mix_t pending_mix [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int beats_in = 0;
  int samples_out = 0;
  int clip_seen = 0;
  longint cycles = 0;

  function automatic int unsigned word_key(int unsigned c, int unsigned b, int unsigned ix);
    return (c * NB + b) * MAXWL + ix;
  endfunction

  function automatic int unsigned eff_wl(int unsigned b);
    int unsigned w;
    w = band_wl[b];
    if (w == 0) w = 1;
    if (w > MAXWL) w = MAXWL;
    return w;
  endfunction

  function automatic int unsigned read_phase(int unsigned b);
    return (phase_ctr[b] >= eff_wl(b)) ? 0 : phase_ctr[b];
  endfunction

  function automatic bit voice_live(int unsigned v);
    return energy_old[v] > ENERGY_FLOOR || energy_cur[v] > ENERGY_FLOOR;
  endfunction

  function automatic logic signed [15:0] sat_q15(longint acc);
    longint q;
    q = acc / SCALE;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // apply one accepted beat to the bank state; returns 1 with the mix on generate
  function automatic bit mix_step(item_t it, output mix_t res);
    longint lsum, rsum, amp, en, pl, pr, bef, cur;
    int st, fin, s;
    int unsigned nb, v, w;
    bit clip;
    lsum = 0; rsum = 0; clip = 0;
    res = '{0, 0, 0};
    case (it.cmd)
      CMD_SETUP: begin
        band_wl[it.band] = it.wavelength;
        band_pan_q[it.band] = it.pan_value;
        band_off[it.band] = it.offset_value;
        phase_ctr[it.band] = 0;
        return 0;
      end
      CMD_WORD: begin
        if (it.color < COLORS)
          wave_words[word_key(it.color, it.band, it.table_index)] = it.table_value;
        return 0;
      end
      CMD_ENERGY: begin
        if (it.color < COLORS) begin
          v = it.color * NB + it.band;
          energy_old[v] = energy_cur[v];
          energy_cur[v] = it.energy_value;
        end
        return 0;
      end
      default: begin
        nb = (nbands_cfg > NB) ? NB : nbands_cfg;
        s = it.position;
        for (int unsigned b = 0; b < nb; b++) begin
          st = int'(band_off[b]) - RAMP;
          if (st < 0) st = 0;
          fin = st + RAMP;
          if (fin >= int'(seglen_cfg)) fin = seglen_cfg;
          pl = band_pan_q[b];
          pr = 65536 - pl;
          for (int unsigned c = 0; c < COLORS; c++) begin
            v = c * NB + b;
            if (!voice_live(v)) continue;
            bef = energy_old[v];
            cur = energy_cur[v];
            if (s > st && s < fin) en = bef + (longint'(s - st) * (cur - bef)) / RAMP;
            else if (s >= fin) en = cur;
            else en = bef;
            w = wave_words[word_key(c, b, read_phase(b))];
            amp = longint'($signed(w[15:0])) * en;
            lsum += amp * pl;
            rsum += amp * pr;
            if (lsum > UNITY || lsum < -UNITY || rsum > UNITY || rsum < -UNITY) clip = 1;
          end
        end
        for (int unsigned b = 0; b < NB; b++)
          phase_ctr[b] = (phase_ctr[b] + 1 >= eff_wl(b)) ? 0 : phase_ctr[b] + 1;
        res.l = sat_q15(lsum);
        res.r = sat_q15(rsum);
        res.c = clip;
        return 1;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch @%0t sample %0d: %s got %0d expected %0d",
             $time, samples_out, what, got, want);
  endtask

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** wavetable_additive_band_mixer_top: FAILED **");
      $finish;
    end
  end

  // receive side: random back-pressure, compare each result beat
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    mix_t want;
    if (!rst && out_valid && out_ready) begin
      samples_out++;
      if (pending_mix.size() == 0) begin
        report_mismatch("unexpected sample beat", 1, 0);
      end else begin
        want = pending_mix.pop_front();
        if (left_sample !== want.l) report_mismatch("left_sample", left_sample, want.l);
        if (right_sample !== want.r) report_mismatch("right_sample", right_sample, want.r);
        if (clipped !== want.c) report_mismatch("clipped", clipped, want.c);
        if (want.c) clip_seen++;
      end
    end
  end

  // drive one beat, wait for it to be taken, then update the bank state
  task automatic send_beat(item_t it, bit typed = 0, mix_t typed_res = '{0, 0, 0});
    mix_t res;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    cmd = it.cmd;
    band = it.band;
    color = it.color;
    table_index = it.table_index;
    table_value = it.table_value;
    wavelength = it.wavelength;
    pan_value = it.pan_value;
    offset_value = it.offset_value;
    energy_value = it.energy_value;
    position = it.position;
    do @(posedge clk); while (!in_ready);
    beats_in++;
    if (mix_step(it, res)) pending_mix.push_back(typed ? typed_res : res);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // every live voice must read a written wavetable word
  task automatic load_missing_words();
    item_t w;
    int unsigned nb;
    nb = (nbands_cfg > NB) ? NB : nbands_cfg;
    for (int unsigned b = 0; b < nb; b++)
      for (int unsigned c = 0; c < COLORS; c++)
        if (voice_live(c * NB + b) && !wave_words.exists(word_key(c, b, read_phase(b)))) begin
          w = '0;
          w.cmd = CMD_WORD;
          w.band = 6'(b);
          w.color = 2'(c);
          w.table_index = 11'(read_phase(b));
          w.table_value = rand_word();
          send_beat(w);
        end
  endtask

  task automatic issue(item_t it, bit typed = 0, mix_t typed_res = '{0, 0, 0});
    if (it.cmd == CMD_GENERATE) load_missing_words();
    send_beat(it, typed, typed_res);
  endtask

  function automatic item_t random_beat();
    item_t it;
    int unsigned k;
    it.cmd = CMD_SETUP;
    it.band = 6'($urandom);
    it.color = 2'($urandom_range(2));
    it.table_index = 11'($urandom);
    it.table_value = rand_word();
    it.wavelength = 12'($urandom);
    it.pan_value = 16'($urandom);
    it.offset_value = 16'($urandom);
    it.energy_value = 16'($urandom);
    it.position = 16'($urandom);
    k = $urandom_range(99);
    if (k < 10) begin
      it.cmd = CMD_SETUP;
      case ($urandom_range(9))
        0: it.wavelength = 0;
        1: it.wavelength = 12'($urandom_range(4095, 2000));
        default: it.wavelength = 12'($urandom_range(16, 1));
      endcase
      if ($urandom_range(3) != 0) it.offset_value = 16'($urandom_range(700));
    end else if (k < 35) begin
      it.cmd = CMD_WORD;
      if ($urandom_range(3) != 0) it.table_index = 11'($urandom_range(15));
      if ($urandom_range(3) != 0) it.band = 6'($urandom_range(7));
    end else if (k < 60) begin
      it.cmd = CMD_ENERGY;
      if ($urandom_range(7) != 0) it.band = 6'($urandom_range(7));
      case ($urandom_range(4))
        0: it.energy_value = 16'($urandom_range(4));
        1: it.energy_value = 16'hffff;
        default: ;
      endcase
    end else if (k < 63) begin
      // ignored color on a load
      it.cmd = $urandom_range(1) ? CMD_WORD : CMD_ENERGY;
      it.color = 3;
    end else begin
      it.cmd = CMD_GENERATE;
      if ($urandom_range(3) != 0) it.position = 16'($urandom_range(900));
    end
    return it;
  endfunction

  task automatic write_reg(reg_index_t idx, int unsigned value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = 16'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_ACTIVE_BANDS) nbands_cfg = value & 'h7f;
    else seglen_cfg = value & 'hffff;
  endtask

  task automatic drain();
    while (pending_mix.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic item_t make_beat(cmd_t c, int unsigned b, int unsigned col,
                                      int unsigned a, int unsigned d);
    item_t it;
    it = '0;
    it.cmd = c;
    it.band = 6'(b);
    it.color = 2'(col);
    case (c)
      CMD_SETUP: begin
        it.wavelength = 12'(a);
        it.pan_value = 16'(d);
        it.offset_value = 16'(a * 3);
      end
      CMD_WORD: begin it.table_index = 11'(a); it.table_value = 16'(d); end
      CMD_ENERGY: it.energy_value = 16'(d);
      default: it.position = 16'(d);
    endcase
    return it;
  endfunction

  initial begin
    row_t rows [$];
    item_t it;
    int unsigned ab [9];
    int unsigned sl [9];
    int per_block;
    int block_end;

    ab = '{1, 4, 0, 127, 8, 3, 64, 6, 2};
    sl = '{1, 65535, 300, 2646, 220, 1000, 500, 2646, 30};
    foreach (energy_cur[i]) begin energy_cur[i] = 0; energy_old[i] = 0; end
    foreach (phase_ctr[i]) phase_ctr[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every band gets a setup so the phase advance never reads an empty entry
    for (int b = 0; b < NB; b++)
      send_beat(make_beat(CMD_SETUP, b, 0, $urandom_range(12, 1), $urandom));

    // directed part: extremes and the named corner cases
    rows.push_back('{make_beat(CMD_GENERATE, 0, 0, 0, 0), 1, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_SETUP, 0, 0, 0, 16'hffff), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_SETUP, 1, 0, 4095, 0), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_WORD, 0, 3, 0, 16'h7fff), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_ENERGY, 0, 3, 0, 16'hffff), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_GENERATE, 0, 0, 0, 0), 1, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_ENERGY, 0, 0, 0, 16'hffff), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_ENERGY, 0, 0, 0, 16'hffff), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_ENERGY, 1, 1, 0, 3), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_ENERGY, 1, 2, 0, 4), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_WORD, 63, 2, 2047, 16'h8000), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_GENERATE, 0, 0, 0, 0), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_GENERATE, 0, 0, 0, 16'hffff), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_ENERGY, 2, 0, 0, 16'hffff), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_ENERGY, 3, 0, 0, 16'hffff), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_ENERGY, 3, 1, 0, 16'hffff), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_GENERATE, 0, 0, 0, 100), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_ENERGY, 0, 0, 0, 0), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_GENERATE, 0, 0, 0, 50), 0, '{0, 0, 0}});
    rows.push_back('{make_beat(CMD_GENERATE, 0, 0, 0, 219), 0, '{0, 0, 0}});
    foreach (rows[i]) issue(rows[i].it, rows[i].typed, rows[i].res);

    // random part across register settings and idle profiles
    per_block = (1950 - beats_in) / 9;
    for (int k = 0; k < 9; k++) begin
      if (k < 3) begin send_idle_pct = 21; recv_idle_pct = 74; end
      else if (k < 6) begin send_idle_pct = 74; recv_idle_pct = 21; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
      drain();
      write_reg(REG_ACTIVE_BANDS, ab[k]);
      write_reg(REG_SEGMENT_LENGTH, sl[k]);
      block_end = beats_in + per_block;
      while (beats_in < block_end) begin
        it = random_beat();
        issue(it);
      end
    end

    while (pending_mix.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d input beats and %0d sample beats (%0d clipped) in %0d cycles",
             beats_in, samples_out, clip_seen, cycles);
    $display("nine register settings, two back-pressure profiles, %0d mismatches", errors);
    if (errors == 0) $display("** wavetable_additive_band_mixer_top: PASSED **");
    else $display("** wavetable_additive_band_mixer_top: FAILED **");
    $finish;
  end
endmodule
